// File: src/fpcsc_pkg.sv
// shared types, constants and crc helper for the framed packet checker
package fpcsc_pkg;

  localparam int MaxPayload = 64;
  localparam int LenW       = 7;

  localparam logic [7:0]  SyncA      = 8'h53;
  localparam logic [7:0]  SyncB      = 8'h41;
  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [15:0] TimeoutRst = 16'd100;
  localparam logic [15:0] CrcInitRst = 16'hFFFF;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic CFG_TIMEOUT  = 1'b0;
  localparam logic CFG_CRC_INIT = 1'b1;

  typedef enum logic [1:0] {
    EV_GOOD    = 2'd0,
    EV_CRCFAIL = 2'd1,
    EV_TIMEOUT = 2'd2
  } event_t;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_SEQ   = 3'd2,
    PH_CMD   = 3'd3,
    PH_LEN   = 3'd4,
    PH_DATA  = 3'd5,
    PH_CRCH  = 3'd6,
    PH_CRCL  = 3'd7
  } phase_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]      event_res;
    logic [7:0]      pkt_seq;
    logic [7:0]      pkt_cmd;
    logic [LenW-1:0] pkt_len;
    logic [15:0]     rx_crc;
    logic            seq_mismatch;
    logic [31:0]     good_total;
    logic [31:0]     crc_fail_total;
    logic [31:0]     timeout_total;
    logic [31:0]     seq_fail_total;
  } result_t;

  // one byte of crc16-ccitt, msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CrcPoly;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: src/framed_packet_crc_seq_checker_core.sv
// framed packet checker: sync hunt, crc16-ccitt, sequence check and event counters
// Takes one transaction per clock unless stalled: a received byte (cmd 0) or a millisecond
// tick (cmd 1). Bytes are framed as 0x53 0x41, seq, cmd, len, len payload bytes and a crc
// trailer, high byte first; the crc is updated a byte per cycle, unless stalled, in the
// state register path. A finished packet or a timeout gives one result, with the event
// counters as they stand after that event. Results pass through an output register backed
// by a skid register, so item_stall rises only when both are full. Configuration writes
// are always ready and should only be made while no result is outstanding.
module framed_packet_crc_seq_checker_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  fpcsc_pkg::item_t   item,
  output logic               res_valid,
  input  logic               res_stall,
  output fpcsc_pkg::result_t res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import fpcsc_pkg::*;

  logic [15:0]     timeout_limit;
  logic [15:0]     crc_init;
  phase_t          phase, phase_next;
  logic [15:0]     run_crc, run_crc_next;
  logic [LenW-1:0] payload_left, payload_left_next;
  logic [7:0]      hold_seq, hold_seq_next;
  logic [7:0]      hold_cmd, hold_cmd_next;
  logic [LenW-1:0] hold_len, hold_len_next;
  logic [7:0]      crc_high, crc_high_next;
  logic [7:0]      prev_seq, prev_seq_next;
  logic            first_pending, first_pending_next;
  logic [15:0]     idle_ticks, idle_ticks_next, idle_inc;
  logic [31:0]     good_cnt, good_cnt_next;
  logic [31:0]     fail_cnt, fail_cnt_next;
  logic [31:0]     tmo_cnt, tmo_cnt_next;
  logic [31:0]     seqf_cnt, seqf_cnt_next;

  logic            item_acc, res_acc;
  logic            emit;
  result_t         emit_res;
  logic            skid_valid;
  result_t         skid;
  logic [15:0]     crc_byte;
  logic [15:0]     rcrc;

  assign cfg_ready  = 1'b1;
  assign item_stall = skid_valid;
  assign item_acc   = item_valid && !item_stall;
  assign res_acc    = res_valid && !res_stall;

  assign crc_byte = crc_feed(run_crc, item.rx_byte);
  assign idle_inc = (idle_ticks == 16'hFFFF) ? idle_ticks : idle_ticks + 16'd1;
  assign rcrc     = {crc_high, item.rx_byte};

  always_comb begin
    phase_next         = phase;
    run_crc_next       = run_crc;
    payload_left_next  = payload_left;
    hold_seq_next      = hold_seq;
    hold_cmd_next      = hold_cmd;
    hold_len_next      = hold_len;
    crc_high_next      = crc_high;
    prev_seq_next      = prev_seq;
    first_pending_next = first_pending;
    idle_ticks_next    = idle_ticks;
    good_cnt_next      = good_cnt;
    fail_cnt_next      = fail_cnt;
    tmo_cnt_next       = tmo_cnt;
    seqf_cnt_next      = seqf_cnt;
    emit               = 1'b0;
    emit_res           = '0;

    if (item.cmd == CMD_TICK) begin
      idle_ticks_next = idle_inc;
      if (phase != PH_HUNT1 && idle_inc > timeout_limit) begin
        tmo_cnt_next      = tmo_cnt + 32'd1;
        phase_next        = PH_HUNT1;
        payload_left_next = '0;
        hold_seq_next     = '0;
        hold_cmd_next     = '0;
        hold_len_next     = '0;
        crc_high_next     = '0;
        idle_ticks_next   = '0;
        emit              = 1'b1;
        emit_res.event_res = EV_TIMEOUT;
      end
    end else begin
      idle_ticks_next = '0;
      case (phase)
        PH_HUNT1: begin
          if (item.rx_byte == SyncA) phase_next = PH_HUNT2;
        end
        PH_HUNT2: begin
          if (item.rx_byte == SyncB) begin
            phase_next   = PH_SEQ;
            run_crc_next = crc_init;
          end else if (item.rx_byte != SyncA) begin
            phase_next = PH_HUNT1;
          end
        end
        PH_SEQ: begin
          hold_seq_next = item.rx_byte;
          run_crc_next  = crc_byte;
          phase_next    = PH_CMD;
        end
        PH_CMD: begin
          hold_cmd_next = item.rx_byte;
          run_crc_next  = crc_byte;
          phase_next    = PH_LEN;
        end
        PH_LEN: begin
          if (item.rx_byte > 8'(MaxPayload)) begin
            // oversize length drops the frame quietly
            phase_next        = PH_HUNT1;
            payload_left_next = '0;
            hold_seq_next     = '0;
            hold_cmd_next     = '0;
            hold_len_next     = '0;
            crc_high_next     = '0;
          end else begin
            hold_len_next     = item.rx_byte[LenW-1:0];
            payload_left_next = item.rx_byte[LenW-1:0];
            run_crc_next      = crc_byte;
            phase_next        = (item.rx_byte != 8'd0) ? PH_DATA : PH_CRCH;
          end
        end
        PH_DATA: begin
          run_crc_next = crc_byte;
          if (payload_left <= LenW'(1)) begin
            payload_left_next = '0;
            phase_next        = PH_CRCH;
          end else begin
            payload_left_next = payload_left - LenW'(1);
          end
        end
        PH_CRCH: begin
          crc_high_next = item.rx_byte;
          phase_next    = PH_CRCL;
        end
        PH_CRCL: begin
          phase_next       = PH_HUNT1;
          emit             = 1'b1;
          emit_res.pkt_seq = hold_seq;
          emit_res.pkt_cmd = hold_cmd;
          emit_res.pkt_len = hold_len;
          emit_res.rx_crc  = rcrc;
          if (rcrc == run_crc) begin
            emit_res.event_res = EV_GOOD;
            good_cnt_next      = good_cnt + 32'd1;
            if (first_pending) begin
              first_pending_next = 1'b0;
            end else if (hold_seq != prev_seq + 8'd1) begin
              emit_res.seq_mismatch = 1'b1;
              seqf_cnt_next         = seqf_cnt + 32'd1;
            end
            prev_seq_next = hold_seq;
          end else begin
            emit_res.event_res = EV_CRCFAIL;
            fail_cnt_next      = fail_cnt + 32'd1;
          end
        end
        default: phase_next = PH_HUNT1;
      endcase
    end

    emit_res.good_total     = good_cnt_next;
    emit_res.crc_fail_total = fail_cnt_next;
    emit_res.timeout_total  = tmo_cnt_next;
    emit_res.seq_fail_total = seqf_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TimeoutRst;
      crc_init      <= CrcInitRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TIMEOUT:  timeout_limit <= cfg_data;
        CFG_CRC_INIT: crc_init      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT1;
      run_crc       <= CrcInitRst;
      payload_left  <= '0;
      hold_seq      <= '0;
      hold_cmd      <= '0;
      hold_len      <= '0;
      crc_high      <= '0;
      prev_seq      <= '0;
      first_pending <= 1'b1;
      idle_ticks    <= '0;
      good_cnt      <= '0;
      fail_cnt      <= '0;
      tmo_cnt       <= '0;
      seqf_cnt      <= '0;
    end else if (item_acc) begin
      phase         <= phase_next;
      run_crc       <= run_crc_next;
      payload_left  <= payload_left_next;
      hold_seq      <= hold_seq_next;
      hold_cmd      <= hold_cmd_next;
      hold_len      <= hold_len_next;
      crc_high      <= crc_high_next;
      prev_seq      <= prev_seq_next;
      first_pending <= first_pending_next;
      idle_ticks    <= idle_ticks_next;
      good_cnt      <= good_cnt_next;
      fail_cnt      <= fail_cnt_next;
      tmo_cnt       <= tmo_cnt_next;
      seqf_cnt      <= seqf_cnt_next;
    end
  end

  // output register with skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!res_valid || res_acc) begin
        if (skid_valid) begin
          res_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          res_valid <= item_acc && emit;
        end
      end else if (item_acc && emit) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || res_acc) begin
      if (skid_valid) res <= skid;
      else if (item_acc && emit) res <= emit_res;
    end
    if (res_valid && !res_acc && item_acc && emit) skid <= emit_res;
  end

`ifndef SYNTH
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid register holds a transaction with output register empty");

  a_trailer_ends_frame : assert property (@(posedge clk) disable iff (rst)
    (item_acc && item.cmd == CMD_BYTE && phase == PH_CRCL) |=> (phase == PH_HUNT1 && res_valid))
    else $error("crc trailer did not return framer to hunt with a result");

  a_byte_clears_idle : assert property (@(posedge clk) disable iff (rst)
    (item_acc && item.cmd == CMD_BYTE) |=> (idle_ticks == 16'd0))
    else $error("received byte did not clear idle tick count");

  a_first_sticky : assert property (@(posedge clk) disable iff (rst)
    !first_pending |=> !first_pending)
    else $error("first packet flag set again outside reset");
`endif

endmodule
